// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/spq_pkg.sv -----
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants for the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_REPORT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]             func;
        logic [VALUE_WIDTH-1:0] value;
    } in_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] top_value;
        logic [CNT_W-1:0]       entry_count;
        logic                   is_empty;
        logic                   is_full;
        logic [1:0]             status;
    } out_t;

    typedef struct packed {
        logic                   insert_en;
        logic                   remove_en;
        logic                   order_desc;
        logic [VALUE_WIDTH-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- src/spq_cell.sv -----
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares, shifts down on insert, up on remove.
// ---------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                   clk,
    input  cell_ctrl_t             ctrl,
    input  logic                   occupied,
    input  logic                   found_in,
    input  logic [VALUE_WIDTH-1:0] prev_value,
    input  logic [VALUE_WIDTH-1:0] next_value,
    output logic                   found_out,
    output logic [VALUE_WIDTH-1:0] value_q,
    output logic [VALUE_WIDTH-1:0] value_nx
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   beats;
    logic                   insert_here;

    always_comb
    begin
        beats       = occupied && (ctrl.order_desc ? (ctrl.value > value_reg)
                                                   : (ctrl.value < value_reg));
        found_out   = found_in | beats;
        insert_here = !found_in && (beats || !occupied);
        value_next  = value_reg;
        if (ctrl.insert_en)
        begin
            if (found_in)
                value_next = prev_value;
            else if (insert_here)
                value_next = ctrl.value;
        end
        else if (ctrl.remove_en)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_q  = value_reg;
    assign value_nx = value_next;

endmodule

// ----- src/sorted_priority_queue.sv -----
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted chain of cells.
// ---------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    in_data  (func, value)
// out       out  out_valid / out_ready  out_data (top, count, flags, status)
// cfg       in   cfg_write_en           cfg_write_data (order_descending)
//
// One request per cycle unless held off by in_ready; the result appears in the cycle after acceptance.
// All cells compare against the new value in the same cycle and shift.
// in_ready is low only while a result waits and out_ready is low.
// Reset empties the queue and selects largest-first; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data,
    input  logic cfg_write_en,
    input  logic cfg_write_data
);

    logic             order_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    out_t             out_reg;
    out_t             out_next;
    logic             accept;
    logic             is_full_now;
    logic             is_empty_now;
    cell_ctrl_t       ctrl;
    status_t          status;
    logic [CNT_W-1:0] count_inc;
    logic             full_insert;
    logic             drop_seen;

    logic [DEPTH:0]         found;
    logic [VALUE_WIDTH-1:0] cell_q  [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_nx [DEPTH];

    assign accept       = in_valid && in_ready;
    assign in_ready     = !out_valid_reg || out_ready;
    assign is_full_now  = (count_reg == CNT_W'(DEPTH));
    assign is_empty_now = (count_reg == '0);

    always_comb
    begin
        ctrl.insert_en  = accept && (in_data.func == FUNC_INSERT) && !is_full_now;
        ctrl.remove_en  = accept && (in_data.func == FUNC_REMOVE) && !is_empty_now;
        ctrl.order_desc = order_reg;
        ctrl.value      = in_data.value;
        count_next      = count_reg;
        status          = ST_OK;
        case (in_data.func)
            FUNC_INSERT:
            begin
                if (is_full_now)
                    status = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            FUNC_REMOVE:
            begin
                if (is_empty_now)
                    status = ST_EMPTY;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            FUNC_CLEAR:  count_next = '0;
            default:     ;
        endcase
        out_next.top_value   = (count_next != '0) ? cell_nx[0] : '0;
        out_next.entry_count = count_next;
        out_next.is_empty    = (count_next == '0);
        out_next.is_full     = (count_next == CNT_W'(DEPTH));
        out_next.status      = status;
    end

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_v;
        logic [VALUE_WIDTH-1:0] next_v;

        if (i == 0)
        begin : g_first
            assign prev_v = in_data.value;
        end
        else
        begin : g_mid
            assign prev_v = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_v = cell_q[i];
        end
        else
        begin : g_inner
            assign next_v = cell_q[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (CNT_W'(i) < count_reg),
            .found_in   (found[i]),
            .prev_value (prev_v),
            .next_value (next_v),
            .found_out  (found[i+1]),
            .value_q    (cell_q[i]),
            .value_nx   (cell_nx[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                order_reg <= cfg_write_data;
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign count_inc   = count_reg + CNT_W'(1);
    assign full_insert = accept && (in_data.func == FUNC_INSERT) && is_full_now;
    assign drop_seen   = is_full_now && (out_data.status == ST_FULL);

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH), "count over depth")
    `ASSERT_NEXT(a_insert_grows, clk, rst_n, ctrl.insert_en, count_reg == $past(count_inc), "")
    `ASSERT_NEXT(a_full_drop, clk, rst_n, full_insert, drop_seen, "insert on full not dropped")

endmodule
